>>> hdl/dics_pkg.sv
// Package for the discrete inverse-CDF sampler: field widths, item layouts,
// request codes and the command/status structs between controller and datapath.
// No dependencies.
package dics_pkg;

    localparam int ROWS_DEF = 16;
    localparam int BINS_DEF = 64;

    localparam int ROW_IN_W = 4;
    localparam int BIN_IN_W = 6;
    localparam int VAL_W    = 16;
    localparam int CFG_W    = 7;
    localparam int ACC_W    = 24;
    localparam int OUT_BIN_W = 6;

    localparam logic [CFG_W-1:0] ACTIVE_RESET = CFG_W'(64);
    localparam logic [ACC_W-1:0] ACC_MAX      = {ACC_W{1'b1}};

    // s_tdata layout, lowest bit first: row, bin, weight, draw
    localparam int ROW_LSB    = 0;
    localparam int BIN_LSB    = ROW_LSB + ROW_IN_W;
    localparam int WEIGHT_LSB = BIN_LSB + BIN_IN_W;
    localparam int DRAW_LSB   = WEIGHT_LSB + VAL_W;
    localparam int S_FIELDS_W = DRAW_LSB + VAL_W;
    localparam int S_TDATA_W  = ((S_FIELDS_W + 7) / 8) * 8;
    localparam int M_TDATA_W  = ((OUT_BIN_W + 7) / 8) * 8;

    // request kind carried in s_tuser
    localparam logic REQ_WRITE  = 1'b0;
    localparam logic REQ_SAMPLE = 1'b1;

    typedef struct packed {
        logic clear;     // write zero at the sweep address, advance
        logic wr;        // store the weight of the accepted item
        logic load;      // latch a sample item and restart the walk
        logic walk;      // issue the next read, fold in returned weight
        logic out_load;  // move the walk result into the output register
    } dics_cmd_t;

    typedef struct packed {
        logic clear_last;  // sweep is at the last entry
        logic walk_done;   // hit found, bad request, or all bins summed
    } dics_status_t;

endpackage

>>> hdl/dics_ctrl.sv
// Controller for the discrete inverse-CDF sampler: clear sweep, idle,
// walk and finish sequencing plus the output valid flag.
// Depends on dics_pkg.
module dics_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [0:0]            s_tuser,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    input  dics_pkg::dics_status_t status,
    output dics_pkg::dics_cmd_t   cmd
);
    import dics_pkg::*;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_WALK,
        ST_FINISH
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   accept;

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign m_tvalid = out_valid_reg;

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg && !m_tready;
        cmd            = '0;
        case (state_reg)
            ST_CLEAR:
            begin
                cmd.clear = 1'b1;
                if (status.clear_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (s_tuser[0] == REQ_SAMPLE)
                    begin
                        cmd.load   = 1'b1;
                        state_next = ST_WALK;
                    end
                    else
                    begin
                        cmd.wr = 1'b1;
                    end
                end
            end
            ST_WALK:
            begin
                cmd.walk = 1'b1;
                if (status.walk_done)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                // hold the result until the output register is free
                if (!out_valid_reg || m_tready)
                begin
                    cmd.out_load   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

>>> hdl/dics_datapath.sv
// Datapath for the discrete inverse-CDF sampler: weight memory, clear
// sweep, bin walk with saturating accumulator, config and output registers.
// Depends on dics_pkg.
module dics_datapath #(
    parameter int ROWS = dics_pkg::ROWS_DEF,
    parameter int BINS = dics_pkg::BINS_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  dics_pkg::dics_cmd_t              cmd,
    output dics_pkg::dics_status_t           status,
    input  logic [dics_pkg::S_TDATA_W-1:0]   s_tdata,
    input  logic                             cfg_wr_en,
    input  logic [dics_pkg::CFG_W-1:0]       cfg_wr_data,
    output logic [dics_pkg::M_TDATA_W-1:0]   m_tdata,
    output logic [0:0]                       m_tuser
);
    import dics_pkg::*;

    localparam int DEPTH  = ROWS * BINS;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int K_W    = $clog2(BINS + 1);
    localparam int LIM_W  = (K_W > CFG_W) ? K_W : CFG_W;

    logic [ROW_IN_W-1:0] in_row;
    logic [BIN_IN_W-1:0] in_bin;
    logic [VAL_W-1:0]    in_weight;
    logic [VAL_W-1:0]    in_draw;

    assign in_row    = s_tdata[BIN_LSB-1:ROW_LSB];
    assign in_bin    = s_tdata[WEIGHT_LSB-1:BIN_LSB];
    assign in_weight = s_tdata[DRAW_LSB-1:WEIGHT_LSB];
    assign in_draw   = s_tdata[S_FIELDS_W-1:DRAW_LSB];

    // weight memory
    logic [VAL_W-1:0]  mem [DEPTH];
    logic [VAL_W-1:0]  rdata_reg;
    logic              mem_we;
    logic [ADDR_W-1:0] mem_waddr;
    logic [VAL_W-1:0]  mem_wdata;
    logic [ADDR_W-1:0] rd_addr;

    logic [ADDR_W-1:0] clr_addr_reg, clr_addr_next;
    logic [CFG_W-1:0]  active_bins_reg;

    logic [ADDR_W-1:0] base_reg;
    logic [VAL_W-1:0]  draw_reg;
    logic [K_W-1:0]    limit_reg;
    logic              bad_reg;
    logic [K_W-1:0]    rd_k_reg, rd_k_next;
    logic              pend_reg, pend_next;
    logic [K_W-1:0]    pend_k_reg;
    logic [ACC_W-1:0]  acc_reg, acc_next;
    logic              hit_reg, hit_next;
    logic [K_W-1:0]    bin_reg, bin_next;

    logic [OUT_BIN_W-1:0] res_bin_reg;
    logic                 res_err_reg;

    logic              wr_ok;
    logic [ADDR_W-1:0] wr_addr;
    logic              row_bad;
    logic [LIM_W-1:0]  act_ext;
    logic [LIM_W-1:0]  bins_ext;
    logic [K_W-1:0]    limit_in;
    logic              issue;
    logic [ACC_W:0]    acc_sum;
    logic [ACC_W-1:0]  acc_sat;

    assign wr_ok   = (32'(in_row) < 32'(ROWS)) && (32'(in_bin) < 32'(BINS));
    assign wr_addr = ADDR_W'(32'(in_row) * 32'(BINS) + 32'(in_bin));
    assign row_bad = 32'(in_row) >= 32'(ROWS);

    // clamp the active count to the row length
    assign act_ext  = LIM_W'(active_bins_reg);
    assign bins_ext = LIM_W'(BINS);
    assign limit_in = (act_ext > bins_ext) ? K_W'(bins_ext) : K_W'(act_ext);

    assign mem_we    = cmd.clear || (cmd.wr && wr_ok);
    assign mem_waddr = cmd.clear ? clr_addr_reg : wr_addr;
    assign mem_wdata = cmd.clear ? '0 : in_weight;
    assign rd_addr   = base_reg + ADDR_W'(rd_k_reg);

    assign clr_addr_next     = clr_addr_reg + ADDR_W'(1);
    assign status.clear_last = (clr_addr_reg == ADDR_W'(DEPTH - 1));
    assign status.walk_done  = hit_reg || bad_reg
                               || ((rd_k_reg == limit_reg) && !pend_reg);

    assign issue   = cmd.walk && !hit_reg && !bad_reg && (rd_k_reg < limit_reg);
    assign acc_sum = {1'b0, acc_reg} + (ACC_W + 1)'(rdata_reg);
    assign acc_sat = acc_sum[ACC_W] ? ACC_MAX : acc_sum[ACC_W-1:0];

    always_comb
    begin
        rd_k_next = issue ? rd_k_reg + K_W'(1) : rd_k_reg;
        pend_next = issue;
        acc_next  = acc_reg;
        hit_next  = hit_reg;
        bin_next  = bin_reg;
        // fold in the weight returned for the previous read
        if (cmd.walk && pend_reg && !hit_reg)
        begin
            acc_next = acc_sat;
            if (ACC_W'(draw_reg) < acc_sat)
            begin
                hit_next = 1'b1;
                bin_next = pend_k_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        rdata_reg <= mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_addr_reg    <= '0;
            active_bins_reg <= ACTIVE_RESET;
            pend_reg        <= 1'b0;
            hit_reg         <= 1'b0;
            bad_reg         <= 1'b0;
        end
        else
        begin
            if (cmd.clear)
            begin
                clr_addr_reg <= clr_addr_next;
            end
            if (cfg_wr_en)
            begin
                active_bins_reg <= cfg_wr_data;
            end
            if (cmd.load)
            begin
                pend_reg <= 1'b0;
                hit_reg  <= 1'b0;
                bad_reg  <= row_bad || (limit_in == '0);
            end
            else
            begin
                pend_reg <= pend_next;
                hit_reg  <= hit_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            base_reg  <= ADDR_W'(32'(in_row) * 32'(BINS));
            draw_reg  <= in_draw;
            limit_reg <= limit_in;
            rd_k_reg  <= '0;
            acc_reg   <= '0;
            bin_reg   <= '0;
        end
        else
        begin
            rd_k_reg <= rd_k_next;
            acc_reg  <= acc_next;
            bin_reg  <= bin_next;
        end
        pend_k_reg <= rd_k_reg;
        if (cmd.out_load)
        begin
            res_bin_reg <= hit_reg ? OUT_BIN_W'(bin_reg) : '0;
            res_err_reg <= !hit_reg;
        end
    end

    assign m_tdata = M_TDATA_W'(res_bin_reg);
    assign m_tuser = res_err_reg;

endmodule

>>> hdl/discrete_inverse_cdf_sampler_top.sv
// Top level of the discrete inverse-CDF sampler: controller plus datapath.
// Depends on dics_pkg, dics_ctrl and dics_datapath.
//
//  channel  dir   handshake           payload
//  s_*      in    s_tvalid/s_tready   s_tdata {draw,weight,bin,row}, s_tuser req_type
//  m_*      out   m_tvalid/m_tready   m_tdata sampled_bin, m_tuser not_a_law
//  cfg_*    in    cfg_wr_en           cfg_wr_data active_bins
//
// After reset the weight memory is swept to zero, one entry a cycle, with
// s_tready low; configuration writes are taken during the sweep.
// A write item leaves the block ready for the next item. A sample item holds
// s_tready low through the walk over the row through the single memory read
// port and the finish step; the walk stops early at the first bin that covers the draw.
// The output register holds a result while m_tready is low; the next item is
// accepted meanwhile, and a later sample waits in its finish step until the
// register drains.
module discrete_inverse_cdf_sampler_top #(
    parameter int ROWS = dics_pkg::ROWS_DEF,
    parameter int BINS = dics_pkg::BINS_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    // input items
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [dics_pkg::S_TDATA_W-1:0] s_tdata,  // row[3:0] bin[9:4] weight[25:10] draw[41:26]
    input  logic [0:0]                     s_tuser,  // req_type[0]
    // result items
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [dics_pkg::M_TDATA_W-1:0] m_tdata,  // sampled_bin[5:0]
    output logic [0:0]                     m_tuser,  // not_a_law[0]
    // active bin count register
    input  logic                           cfg_wr_en,
    input  logic [dics_pkg::CFG_W-1:0]     cfg_wr_data
);
    import dics_pkg::*;

    dics_cmd_t    cmd;
    dics_status_t status;

    // sequence the sweep, item acceptance, walk and result hand-off
    dics_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .status   (status),
        .cmd      (cmd)
    );

    // memory, accumulator and result registers
    dics_datapath #(
        .ROWS (ROWS),
        .BINS (BINS)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .status      (status),
        .s_tdata     (s_tdata),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser)
    );

endmodule

>>> hdl/dics_checker.sv
// Port-level checks for the discrete inverse-CDF sampler, bound to the top.
// Depends on dics_pkg and discrete_inverse_cdf_sampler_top.
module dics_checker (
    input logic                           clk,
    input logic                           rst_n,
    input logic                           s_tvalid,
    input logic                           s_tready,
    input logic [dics_pkg::S_TDATA_W-1:0] s_tdata,
    input logic [0:0]                     s_tuser,
    input logic                           m_tvalid,
    input logic                           m_tready,
    input logic [dics_pkg::M_TDATA_W-1:0] m_tdata,
    input logic [0:0]                     m_tuser
);
    import dics_pkg::*;

    // stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    // an error result carries bin zero
    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[0] |-> m_tdata == '0)
        else $error("error result with nonzero bin");

    // memory sweep blocks input right after reset
    a_sweep: assert property (@(posedge clk) disable iff (!rst_n)
        $past(!rst_n) |-> !s_tready)
        else $error("input accepted during clear sweep");

    // a write item produces no result
    a_write_silent: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && s_tuser[0] == REQ_WRITE && !m_tvalid |=> !m_tvalid)
        else $error("result after write item");

    // a sample item occupies the walk
    a_sample_busy: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && s_tuser[0] == REQ_SAMPLE |=> !s_tready)
        else $error("ready right after sample item");

endmodule

bind discrete_inverse_cdf_sampler_top dics_checker u_dics_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

>>> tb/dics_draw_checker.sv
// Checker for the discrete inverse-CDF sampler: mirrors the weight table and the
// active bin count, predicts every sample result and compares the result channel.
// Depends on dics_pkg.
module dics_draw_checker #(
    parameter int ROWS = dics_pkg::ROWS_DEF,
    parameter int BINS = dics_pkg::BINS_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_tvalid,
    input  logic                           s_tready,
    input  logic [dics_pkg::S_TDATA_W-1:0] s_tdata,
    input  logic [0:0]                     s_tuser,
    input  logic                           m_tvalid,
    input  logic                           m_tready,
    input  logic [dics_pkg::M_TDATA_W-1:0] m_tdata,
    input  logic [0:0]                     m_tuser,
    input  logic                           cfg_wr_en,
    input  logic [dics_pkg::CFG_W-1:0]     cfg_wr_data,
    output int                             fail_count,
    output int                             pending,
    output int                             results_seen,
    output int                             no_hit_seen
);
    import dics_pkg::*;

    typedef struct packed {
        logic [OUT_BIN_W-1:0] bin;
        logic                 no_hit;
    } draw_outcome_t;

    logic [VAL_W-1:0] weights [ROWS][BINS];
    logic [CFG_W-1:0] bins_in_use;
    draw_outcome_t    outcomes_due [$];

    // Walk the row, add weights into a saturating accumulator, stop at the first
    // bin whose running sum is above the draw.
    function automatic draw_outcome_t predict_draw(input logic [ROW_IN_W-1:0] row,
                                                   input logic [VAL_W-1:0] draw);
        draw_outcome_t   res;
        int              span;
        logic [ACC_W-1:0] running;
        logic [ACC_W:0]   widened;
        res.bin    = '0;
        res.no_hit = 1'b1;
        if (int'(row) >= ROWS)
            return res;
        span    = (int'(bins_in_use) > BINS) ? BINS : int'(bins_in_use);
        running = '0;
        for (int k = 0; k < span; k++)
        begin
            widened = {1'b0, running} + (ACC_W + 1)'(weights[row][k]);
            running = widened[ACC_W] ? ACC_MAX : widened[ACC_W-1:0];
            if (ACC_W'(draw) < running)
            begin
                res.bin    = OUT_BIN_W'(k);
                res.no_hit = 1'b0;
                return res;
            end
        end
        return res;
    endfunction

    task automatic take_item();
        logic [ROW_IN_W-1:0] row;
        logic [BIN_IN_W-1:0] bin;
        row = s_tdata[ROW_LSB +: ROW_IN_W];
        bin = s_tdata[BIN_LSB +: BIN_IN_W];
        if (s_tuser[0] == REQ_SAMPLE)
            outcomes_due = {outcomes_due, predict_draw(row, s_tdata[DRAW_LSB +: VAL_W])};
        else if (int'(row) < ROWS && int'(bin) < BINS)
            weights[row][bin] = s_tdata[WEIGHT_LSB +: VAL_W];
    endtask

    task automatic check_result();
        draw_outcome_t due;
        results_seen++;
        if (m_tuser[0])
            no_hit_seen++;
        if (outcomes_due.size() == 0)
        begin
            $error("result with no sample waiting: sampled_bin %0d not_a_law %0d",
                   m_tdata[OUT_BIN_W-1:0], m_tuser[0]);
            fail_count++;
            return;
        end
        due = outcomes_due.pop_front();
        if (m_tdata[OUT_BIN_W-1:0] !== due.bin)
        begin
            $error("sampled_bin: expected %0d, got %0d", due.bin, m_tdata[OUT_BIN_W-1:0]);
            fail_count++;
        end
        if (m_tuser[0] !== due.no_hit)
        begin
            $error("not_a_law: expected %0d, got %0d", due.no_hit, m_tuser[0]);
            fail_count++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int r = 0; r < ROWS; r++)
                for (int b = 0; b < BINS; b++)
                    weights[r][b] = '0;
            bins_in_use = ACTIVE_RESET;
            outcomes_due.delete();
            pending      = 0;
            fail_count   = 0;
            results_seen = 0;
            no_hit_seen  = 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
                check_result();
            if (s_tvalid && s_tready)
                take_item();
            if (cfg_wr_en)
                bins_in_use = cfg_wr_data;
            pending = outcomes_due.size();
        end
    end

endmodule

>>> tb/testbench.sv
// Top of the sampler testbench: clock, reset, item stimulus, result sink and verdict.
// Depends on dics_pkg, discrete_inverse_cdf_sampler_top and dics_draw_checker.
module testbench;
    import dics_pkg::*;

    localparam int ITEMS        = 1950;
    localparam int PHASES       = 8;
    localparam int DRAIN_CYCLES = BINS_DEF + 16;    // longest sample walk plus margin
    localparam int CYCLE_LIMIT  = 1_500_000;

    logic                 clk;
    logic                 rst_n;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata;
    logic [0:0]           s_tuser;
    logic                 m_tvalid;
    logic                 m_tready;
    logic [M_TDATA_W-1:0] m_tdata;
    logic [0:0]           m_tuser;
    logic                 cfg_wr_en;
    logic [CFG_W-1:0]     cfg_wr_data;

    int fail_count;
    int pending;
    int results_seen;
    int no_hit_seen;

    int cycle_count = 0;
    int items_sent  = 0;
    int writes_sent = 0;
    int draws_sent  = 0;
    bit tx_steady   = 1'b0;   // sender runs back to back while set
    bit rx_steady   = 1'b0;   // receiver starts no new stall while set

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    discrete_inverse_cdf_sampler_top uut (
        .clk         (clk),
        .rst_n       (rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    dics_draw_checker checker_i (
        .clk          (clk),
        .rst_n        (rst_n),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .s_tuser      (s_tuser),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .m_tuser      (m_tuser),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .fail_count   (fail_count),
        .pending      (pending),
        .results_seen (results_seen),
        .no_hit_seen  (no_hit_seen)
    );

    // Idle lengths: mostly none, some short, a few long.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Draw values: the two extremes now and then, often a value inside the
    // row's filled mass so that hits are common, otherwise anything.
    function automatic logic [VAL_W-1:0] pick_draw(input int mass);
        int r;
        r = $urandom_range(0, 99);
        if (r < 10)
            return '0;
        if (r < 20)
            return '1;
        if (r < 60)
            return VAL_W'($urandom_range(0, (mass > 65535) ? 65535 : mass));
        return VAL_W'($urandom);
    endfunction

    // Drive one item and hold it until the block takes it. Enter and leave on a
    // falling edge; tvalid stays high on return so a back-to-back item does not
    // drop and raise it within one step.
    task automatic send_item(input logic kind, input logic [ROW_IN_W-1:0] row,
                             input logic [BIN_IN_W-1:0] bin, input logic [VAL_W-1:0] weight,
                             input logic [VAL_W-1:0] draw);
        int                   gap;
        logic [S_TDATA_W-1:0] word;
        gap = tx_steady ? 0 : pick_gap();
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        word = '0;
        word[ROW_LSB +: ROW_IN_W]  = row;
        word[BIN_LSB +: BIN_IN_W]  = bin;
        word[WEIGHT_LSB +: VAL_W]  = weight;
        word[DRAW_LSB +: VAL_W]    = draw;
        s_tvalid <= 1'b1;
        s_tdata  <= word;
        s_tuser  <= kind;
        do
            @(posedge clk);
        while (!s_tready);
        @(negedge clk);
        items_sent++;
        if (kind == REQ_SAMPLE)
            draws_sent++;
        else
            writes_sent++;
    endtask

    // Fill the unused fields with noise so every bit toggles on both kinds.
    task automatic send_write(input logic [ROW_IN_W-1:0] row, input logic [BIN_IN_W-1:0] bin,
                              input logic [VAL_W-1:0] weight);
        send_item(REQ_WRITE, row, bin, weight, VAL_W'($urandom));
    endtask

    task automatic send_sample(input logic [ROW_IN_W-1:0] row, input logic [VAL_W-1:0] draw);
        send_item(REQ_SAMPLE, row, BIN_IN_W'($urandom), VAL_W'($urandom), draw);
    endtask

    // Write the active bin count; called during the clear sweep or after a drain.
    task automatic set_active(input logic [CFG_W-1:0] count);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= count;
        @(negedge clk);
        cfg_wr_en   <= 1'b0;
        @(negedge clk);
    endtask

    // Stop sending, wait for every expected result, then let a trailing write
    // or walk finish before anything else touches the block.
    task automatic drain();
        s_tvalid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    // Edge values first: empty table, single full-scale bin, exact boundary
    // between miss and hit, last row and last bin, zero weights.
    task automatic run_directed();
        send_sample(4'd0, 16'h0000);        // empty row, expect no hit
        send_write(4'd0, 6'd0, 16'hFFFF);
        send_sample(4'd0, 16'hFFFE);        // hit on bin 0
        send_sample(4'd0, 16'hFFFF);        // sum equals draw, miss
        send_write(4'd0, 6'd1, 16'h0001);
        send_sample(4'd0, 16'hFFFF);        // crosses on bin 1
        send_sample(4'd0, 16'h0000);
        send_write(4'd15, 6'd63, 16'hFFFF);
        send_sample(4'd15, 16'h0000);       // only the last bin carries weight
        send_sample(4'd15, 16'hFFFF);
        send_write(4'd15, 6'd62, 16'h0001);
        send_sample(4'd15, 16'hFFFF);       // hit on the last bin
        send_write(4'd7, 6'd5, 16'h0000);
        send_sample(4'd7, 16'h0000);        // zero weight never covers the draw
        send_write(4'd3, 6'd0, 16'h5555);
        send_write(4'd3, 6'd1, 16'hAAAA);
        send_sample(4'd3, 16'h5554);
        send_sample(4'd3, 16'h5555);
        send_sample(4'd3, 16'hFFFE);
        send_sample(4'd3, 16'hFFFF);
        send_write(4'd0, 6'd0, 16'h0000);   // overwrite a stored weight
        send_sample(4'd0, 16'h0000);
    endtask

    // One stretch of traffic: usually fill part or all of a row and sample it a few
    // times; sometimes a stray item of either kind.
    task automatic run_episode();
        logic [ROW_IN_W-1:0] row;
        logic [VAL_W-1:0]    ceiling;
        int                  count;
        int                  first;
        int                  shots;
        row       = ROW_IN_W'($urandom_range(0, 15));
        tx_steady = ($urandom_range(0, 5) == 0);
        rx_steady = ($urandom_range(0, 5) == 0);
        if ($urandom_range(0, 4) == 0)
        begin
            if ($urandom_range(0, 1) == 1)
                send_write(row, BIN_IN_W'($urandom), VAL_W'($urandom));
            else
                send_sample(row, VAL_W'($urandom));
            return;
        end
        case ($urandom_range(0, 4))
            0:       ceiling = 16'hFFFF;
            1:       ceiling = 16'h3FFF;
            2:       ceiling = 16'h0FFF;
            3:       ceiling = 16'h00FF;
            default: ceiling = 16'h000F;
        endcase
        count = ($urandom_range(0, 9) == 0) ? BINS_DEF : $urandom_range(1, 12);
        first = ($urandom_range(0, 2) == 0) ? $urandom_range(0, BINS_DEF - count) : 0;
        for (int b = first; b < first + count; b++)
            send_write(row, BIN_IN_W'(b), VAL_W'($urandom_range(0, ceiling)));
        shots = $urandom_range(1, 8);
        for (int s = 0; s < shots; s++)
            send_sample(row, pick_draw(int'(ceiling) * count));
    endtask

    // Result sink: hold tready low for random stretches unless told to run free.
    initial
    begin : result_sink
        int hold;
        hold     = 0;
        m_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold == 0 && !rx_steady && $urandom_range(0, 3) == 0)
                hold = pick_gap();
            if (hold > 0)
            begin
                m_tready <= 1'b0;
                hold--;
            end
            else
                m_tready <= 1'b1;
        end
    end

    // Watchdog: end the run if the block hangs.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    initial
    begin : stimulus
        int active_plan [PHASES];
        int phase_end;
        active_plan = '{64, 1, 127, 0, 2, 63, 65, 0};
        active_plan[PHASES-1] = $urandom_range(1, 127);

        rst_n       = 1'b0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        s_tuser     = '0;
        cfg_wr_en   = 1'b0;
        cfg_wr_data = '0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Walk through the active-count settings: reset value, one bin, above
        // the bin count, zero, and a few in between. The register is first written
        // during the clear sweep, later only once the block has gone quiet.
        for (int p = 0; p < PHASES; p++)
        begin
            set_active(CFG_W'(active_plan[p]));
            if (p == 0)
                run_directed();
            phase_end = (p + 1) * ITEMS / PHASES;
            while (items_sent < phase_end)
                run_episode();
            drain();
        end

        $display("Sent %0d weight writes and %0d samples across %0d active-bin settings",
                 writes_sent, draws_sent, PHASES);
        $display("Checked %0d results, %0d of them flagged as not a distribution",
                 results_seen, no_hit_seen);
        if (fail_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

>>> discrete_inverse_cdf_sampler_top.f
hdl/dics_pkg.sv
hdl/dics_ctrl.sv
hdl/dics_datapath.sv
hdl/discrete_inverse_cdf_sampler_top.sv
hdl/dics_checker.sv
tb/dics_draw_checker.sv
tb/testbench.sv
